>>> src/sha256_pkg.sv
`default_nettype none

package sha256_pkg;

  // fill position of the last byte of a block
  localparam logic [5:0] LastFill = 6'd63;
  // fill position of the last pad byte before the 64-bit length field
  localparam logic [5:0] PadEndFill = 6'd55;
  // last round of a compression
  localparam logic [5:0] LastRound = 6'd63;
  // last word of the digest
  localparam logic [2:0] LastWord = 3'd7;
  // first pad byte after the message
  localparam logic [7:0] PadByte = 8'h80;

  // source of the byte shifted into the block register
  typedef enum logic [1:0] {
    BYTE_MSG  = 2'd0,
    BYTE_PAD  = 2'd1,
    BYTE_ZERO = 2'd2,
    BYTE_LEN  = 2'd3
  } byte_sel_e;

  // controller to datapath commands
  typedef struct packed {
    logic      shift_en;
    byte_sel_e byte_sel;
    logic      vars_init;
    logic      round_en;
    logic [5:0] round_idx;
    logic      hash_add;
    logic      hash_init;
    logic      len_inc;
    logic      len_clr;
    logic [2:0] out_idx;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [5:0] fill;
  } dp_status_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] round_sum_a(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] round_sum_e(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] sched_mix0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sched_mix1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  // initial hash value for one word
  function automatic logic [31:0] init_hash(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  // round constant table
  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

>>> src/sha256_datapath.sv
`default_nettype none

module sha256_datapath (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire sha256_pkg::dp_cmd_t   cmd_i,
  input  wire logic [7:0]            message_byte_i,
  output sha256_pkg::dp_status_t     status_o,
  output logic [31:0]                digest_word_o
);

  // block register doubles as the rolling 16-word schedule, word 0 at the top
  logic [511:0]      window_q;
  logic [7:0][31:0]  vars_q;
  logic [7:0][31:0]  hash_q;
  logic [60:0]       len_q;
  logic [5:0]        fill_q;

  logic [7:0]  byte_in;
  logic [63:0] bit_len;
  logic [2:0]  len_sh;
  logic [31:0] w_cur, w_1, w_9, w_14, w_new;
  logic [31:0] t1, t2, ch, maj;

  // byte shifted into the block
  assign bit_len = {len_q, 3'b000};
  assign len_sh  = 3'd7 - fill_q[2:0];

  always_comb begin
    case (cmd_i.byte_sel)
      sha256_pkg::BYTE_MSG:  byte_in = message_byte_i;
      sha256_pkg::BYTE_PAD:  byte_in = sha256_pkg::PadByte;
      sha256_pkg::BYTE_LEN:  byte_in = bit_len[{len_sh, 3'b000} +: 8];
      default:               byte_in = 8'h00;
    endcase
  end

  // message schedule taps
  assign w_cur = window_q[511:480];
  assign w_1   = window_q[479:448];
  assign w_9   = window_q[223:192];
  assign w_14  = window_q[63:32];
  assign w_new = sha256_pkg::sched_mix1(w_14) + w_9 + sha256_pkg::sched_mix0(w_1) + w_cur;

  // round function
  assign ch  = (vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]);
  assign maj = (vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]);
  assign t1  = vars_q[7] + sha256_pkg::round_sum_e(vars_q[4]) + ch
             + sha256_pkg::round_k(cmd_i.round_idx) + w_cur;
  assign t2  = sha256_pkg::round_sum_a(vars_q[0]) + maj;

  // block register and working variables
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_en) begin
      window_q <= {window_q[503:0], byte_in};
    end else if (cmd_i.round_en) begin
      window_q <= {window_q[479:0], w_new};
    end
    if (cmd_i.vars_init) begin
      vars_q <= hash_q;
    end else if (cmd_i.round_en) begin
      vars_q[7] <= vars_q[6];
      vars_q[6] <= vars_q[5];
      vars_q[5] <= vars_q[4];
      vars_q[4] <= vars_q[3] + t1;
      vars_q[3] <= vars_q[2];
      vars_q[2] <= vars_q[1];
      vars_q[1] <= vars_q[0];
      vars_q[0] <= t1 + t2;
    end
  end

  // chaining value, length and fill position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= sha256_pkg::init_hash(3'(i));
      end
      len_q  <= '0;
      fill_q <= '0;
    end else begin
      if (cmd_i.hash_init) begin
        for (int i = 0; i < 8; i++) begin
          hash_q[i] <= sha256_pkg::init_hash(3'(i));
        end
      end else if (cmd_i.hash_add) begin
        for (int i = 0; i < 8; i++) begin
          hash_q[i] <= hash_q[i] + vars_q[i];
        end
      end
      if (cmd_i.len_clr) begin
        len_q <= '0;
      end else if (cmd_i.len_inc) begin
        len_q <= len_q + 61'd1;
      end
      if (cmd_i.shift_en) begin
        fill_q <= fill_q + 6'd1;
      end
    end
  end

  assign status_o.fill = fill_q;
  assign digest_word_o = hash_q[cmd_i.out_idx];

endmodule

`default_nettype wire

>>> src/sha256_ctrl.sv
`default_nettype none

module sha256_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   final_byte_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [2:0]                  word_index_o,
  output logic                        digest_last_o,
  input  wire sha256_pkg::dp_status_t status_i,
  output sha256_pkg::dp_cmd_t         cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PAD   = 6'b000010,
    S_LEN   = 6'b000100,
    S_ROUND = 6'b001000,
    S_UPD   = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e     state_q, state_d;
  logic [5:0] round_q, round_d;
  logic [2:0] out_idx_q, out_idx_d;
  logic       fin_q, fin_d;
  logic       len_in_q, len_in_d;
  logic       pad_first_q, pad_first_d;
  logic       block_full;

  assign block_full = (status_i.fill == sha256_pkg::LastFill);

  // next state and datapath commands
  always_comb begin
    state_d     = state_q;
    round_d     = round_q;
    out_idx_d   = out_idx_q;
    fin_d       = fin_q;
    len_in_d    = len_in_q;
    pad_first_d = pad_first_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o           = '0;
    cmd_o.byte_sel  = sha256_pkg::BYTE_ZERO;
    cmd_o.round_idx = round_q;
    cmd_o.out_idx   = out_idx_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.shift_en = 1'b1;
          cmd_o.byte_sel = sha256_pkg::BYTE_MSG;
          cmd_o.len_inc  = 1'b1;
          fin_d          = final_byte_i;
          pad_first_d    = 1'b1;
          if (block_full) begin
            cmd_o.vars_init = 1'b1;
            round_d         = '0;
            state_d         = S_ROUND;
          end else if (final_byte_i) begin
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd_o.shift_en = 1'b1;
        cmd_o.byte_sel = pad_first_q ? sha256_pkg::BYTE_PAD : sha256_pkg::BYTE_ZERO;
        pad_first_d    = 1'b0;
        if (block_full) begin
          cmd_o.vars_init = 1'b1;
          round_d         = '0;
          state_d         = S_ROUND;
        end else if (status_i.fill == sha256_pkg::PadEndFill) begin
          state_d = S_LEN;
        end
      end
      S_LEN: begin
        cmd_o.shift_en = 1'b1;
        cmd_o.byte_sel = sha256_pkg::BYTE_LEN;
        if (block_full) begin
          cmd_o.vars_init = 1'b1;
          round_d         = '0;
          len_in_d        = 1'b1;
          state_d         = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd_o.round_en = 1'b1;
        round_d        = round_q + 6'd1;
        if (round_q == sha256_pkg::LastRound) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.hash_add = 1'b1;
        if (len_in_q) begin
          out_idx_d = '0;
          state_d   = S_OUT;
        end else if (fin_q) begin
          state_d = S_PAD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          out_idx_d = out_idx_q + 3'd1;
          if (out_idx_q == sha256_pkg::LastWord) begin
            cmd_o.hash_init = 1'b1;
            cmd_o.len_clr   = 1'b1;
            fin_d           = 1'b0;
            len_in_d        = 1'b0;
            state_d         = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      round_q     <= '0;
      out_idx_q   <= '0;
      fin_q       <= 1'b0;
      len_in_q    <= 1'b0;
      pad_first_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      round_q     <= round_d;
      out_idx_q   <= out_idx_d;
      fin_q       <= fin_d;
      len_in_q    <= len_in_d;
      pad_first_q <= pad_first_d;
    end
  end

  assign word_index_o  = out_idx_q;
  assign digest_last_o = (out_idx_q == sha256_pkg::LastWord);

endmodule

`default_nettype wire

>>> src/sha256_message_hasher.sv
// SHA-256 hasher fed one message byte per request, with final_byte_i marking the last
// byte; after it the eight digest words come out as eight output requests, H0 first,
// and the block then starts over from the initial hash for the next message. Every
// 64th byte starts a compression of 64 rounds, one round per cycle on a single round
// unit, followed by a fold of the result into the chaining value; input is blocked
// through both. After the final byte the padding and the 64-bit length are shifted
// into the block register one byte per cycle, with one extra block, compressed on its
// own, when 56 or more bytes of the last block are used; then come the final
// compression and the eight output words. No new byte is taken until the eighth
// digest word has been accepted.
`default_nettype none

module sha256_message_hasher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  message_byte_i,
  input  wire logic        final_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             digest_last_o
);

  sha256_pkg::dp_cmd_t    cmd;
  sha256_pkg::dp_status_t status;

  // sequencing of load, padding, rounds and output
  sha256_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .final_byte_i  (final_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .word_index_o  (word_index_o),
    .digest_last_o (digest_last_o),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // block register, schedule, round unit and chaining value
  sha256_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .message_byte_i (message_byte_i),
    .status_o       (status),
    .digest_word_o  (digest_word_o)
  );

endmodule

`default_nettype wire
